### hw/rtl/mpe_pkg.sv
// Shared types, codes and helpers for the magnitude prune engine.
// No dependencies.
`timescale 1ns / 1ps

package mpe_pkg;

  typedef enum logic [1:0] {
    OP_WR_WEIGHT = 2'd0,
    OP_WR_SCORE  = 2'd1,
    OP_CHECK     = 2'd2,
    OP_RD_WEIGHT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_COLUMN = 2'd1,
    MODE_ROW    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_THRESH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ROWS   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_COLS   = 3'd5;

  localparam int unsigned RankOffset = 1000000;
  localparam logic [12:0] WCountMax  = 13'h1FFF;
  localparam logic [6:0]  UCountMax  = 7'h7F;

  // weight store word
  typedef struct packed {
    logic               mask;
    logic signed [15:0] weight;
  } wword_t;

  // score store word: unit flags ride along with the score of the same entry
  typedef struct packed {
    logic               row_flag;
    logic               col_flag;
    logic               wt_flag;
    logic signed [31:0] score;
  } sword_t;

  function automatic logic [15:0] mag16(input logic signed [15:0] w);
    logic [15:0] r;
    r = w[15] ? 16'(-w) : 16'(w);
    return r;
  endfunction

endpackage

### hw/rtl/mpe_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mpe_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hw/rtl/magnitude_prune_engine.sv
// Magnitude prune engine top level: sequencer, config registers, counters.
// Depends on mpe_pkg and mpe_ram (weight store and score/flag store).
`timescale 1ns / 1ps

// Channel   Signals                                   Direction
// in        in_valid_i/in_ready_o + item fields        request into the block
// out       out_valid_o/out_ready_i + result fields    request out of the block
// cfg       cfg_valid_i/cfg_ready_o, cfg_index_i/data  register write
//
// Steps per request, after accept: a weight/score write, weight read or
// single-weight check reads and executes, a pruning check adding rank steps; a
// column or row check also sums its N weights one by one through the single read
// port of the weight store (N = rows or cols in use), then zeroes them on a prune.
// After reset a clearing pass over all MAX_ROWS*MAX_COLS entries initializes both
// stores; no request is taken meanwhile. One request is in work at a time;
// a finished result waits in the output register while the next is taken, and
// the sequencer holds in its last state while that register is still occupied.

module magnitude_prune_engine #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input requests
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     operation_i,
  input  logic [5:0]                     row_index_i,
  input  logic [5:0]                     col_index_i,
  input  logic signed [15:0]             weight_value_i,
  input  logic signed [31:0]             score_value_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             weight_read_o,
  output logic                           mask_read_o,
  output logic                           unit_pruned_now_o,
  output logic                           unit_was_pruned_o,
  output logic signed [47:0]             rank_value_o,
  output logic [12:0]                    pruned_units_o,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mpe_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import mpe_pkg::*;

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned LW    = (RW > CW) ? RW : CW;
  localparam int unsigned SW    = 16 + LW;

  // sequencer codes
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_EXEC   = 4'd3;
  localparam logic [3:0] S_SUM    = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_ZERO   = 4'd6;
  localparam logic [3:0] S_RANK1  = 4'd7;
  localparam logic [3:0] S_RANK2  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;

  // config registers
  mode_e              mode_q;
  logic [15:0]        thr_q;
  logic signed [31:0] tgt_q;
  logic [30:0]        step_q;
  logic [6:0]         rows_q, cols_q;

  // pruned-unit counters
  logic [12:0] wcount_q;
  logic [6:0]  ccount_q, rcount_q;

  logic [AW-1:0] clr_q;

  // latched request
  op_e                op_q;
  logic [5:0]         row_q, col_q;
  logic signed [15:0] wval_q;
  logic signed [31:0] sval_q;

  // work registers
  sword_t             sword_q;
  logic [AW-1:0]      addr_q, start_q, stride_q, unit_addr_q;
  logic [LW-1:0]      len_q, issue_q, recv_q;
  logic               pend_q;
  logic [SW-1:0]      sum_q, thrlen_q;
  logic signed [32:0] diff_q, base_q;

  // result held while the request is in work
  logic signed [15:0] res_w_q;
  logic               res_m_q, now_q, was_q;
  logic signed [47:0] rank_q;

  logic out_valid_q;

  // memory ports
  logic          wm_we, sm_we;
  logic [AW-1:0] wm_waddr, wm_raddr, sm_waddr, sm_raddr;
  wword_t        wm_wdata, wm_rdata;
  sword_t        sm_wdata, sm_rdata;

  // ---------------------------------------------------------------------------
  // Decode of the latched request
  // ---------------------------------------------------------------------------
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic          row_ok, col_ok, in_store, unit_ok, in_area;
  logic [AW-1:0] widx, unit_addr;
  logic [LW-1:0] len_d;
  logic          unit_flag, w_prune, cr_last;
  logic [47:0]   rank_full;

  always_comb begin
    // used sizes saturate to 1..MAX
    if (rows_q == 7'd0)               nr = RW'(1);
    else if (32'(rows_q) > MAX_ROWS)  nr = RW'(MAX_ROWS);
    else                              nr = RW'(rows_q);
    if (cols_q == 7'd0)               nc = CW'(1);
    else if (32'(cols_q) > MAX_COLS)  nc = CW'(MAX_COLS);
    else                              nc = CW'(cols_q);
  end

  assign row_ok   = 32'(row_q) < MAX_ROWS;
  assign col_ok   = 32'(col_q) < MAX_COLS;
  assign in_store = row_ok && col_ok;
  assign widx     = AW'(32'(row_q) * MAX_COLS + 32'(col_q));

  always_comb begin
    unit_addr = widx;
    unit_ok   = 1'b0;
    in_area   = 1'b0;
    len_d     = LW'(nr);
    unit_flag = 1'b0;
    case (mode_q)
      MODE_WEIGHT: begin
        unit_addr = widx;
        unit_ok   = in_store;
        in_area   = (32'(row_q) < 32'(nr)) && (32'(col_q) < 32'(nc));
        unit_flag = sm_rdata.wt_flag;
      end
      MODE_COLUMN: begin
        unit_addr = AW'(col_q);
        unit_ok   = col_ok;
        in_area   = 32'(col_q) < 32'(nc);
        len_d     = LW'(nr);
        unit_flag = sm_rdata.col_flag;
      end
      MODE_ROW: begin
        unit_addr = AW'(row_q);
        unit_ok   = row_ok;
        in_area   = 32'(row_q) < 32'(nr);
        len_d     = LW'(nc);
        unit_flag = sm_rdata.row_flag;
      end
      default: begin
        unit_ok = 1'b0;
        in_area = 1'b0;
      end
    endcase
  end

  assign w_prune = (state_q == S_EXEC) && (op_q == OP_CHECK) && (mode_q == MODE_WEIGHT)
                && in_area && !sm_rdata.wt_flag
                && ((mag16(wm_rdata.weight) < thr_q) || (sm_rdata.score >= tgt_q));
  assign cr_last = (state_q == S_ZERO) && (issue_q == len_q - LW'(1));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (32'(clr_q) == Depth - 1) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_READ;
      S_READ:   state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        if (op_q == OP_CHECK && in_area && !unit_flag) begin
          if (mode_q == MODE_WEIGHT) begin
            if (w_prune) state_d = S_RANK1;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_SUM:    if (recv_q == len_q) state_d = S_DECIDE;
      S_DECIDE: begin
        if ((sum_q < thrlen_q) || (sword_q.score >= tgt_q)) state_d = S_ZERO;
        else                                                state_d = S_DONE;
      end
      S_ZERO:   if (cr_last) state_d = S_RANK1;
      S_RANK1:  state_d = S_RANK2;
      S_RANK2:  state_d = S_DONE;
      S_DONE:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory access
  // ---------------------------------------------------------------------------
  always_comb begin
    wm_raddr = (state_q == S_SUM) ? addr_q : widx;
    sm_raddr = unit_addr;
    wm_we    = 1'b0;
    wm_waddr = widx;
    wm_wdata = '{mask: 1'b0, weight: 16'sd0};
    sm_we    = 1'b0;
    sm_waddr = unit_addr_q;
    sm_wdata = sword_q;
    case (state_q)
      S_CLEAR: begin
        wm_we    = 1'b1;
        wm_waddr = clr_q;
        wm_wdata = '{mask: 1'b1, weight: 16'sd0};
        sm_we    = 1'b1;
        sm_waddr = clr_q;
        sm_wdata = '0;
      end
      S_EXEC: begin
        case (op_q)
          OP_WR_WEIGHT: begin
            // mask is kept, only the value changes
            wm_we    = in_store;
            wm_wdata = '{mask: wm_rdata.mask, weight: wval_q};
          end
          OP_WR_SCORE: begin
            sm_we          = unit_ok;
            sm_waddr       = unit_addr;
            sm_wdata       = sm_rdata;
            sm_wdata.score = sval_q;
          end
          default: begin
            if (w_prune) begin
              wm_we            = 1'b1;
              sm_we            = 1'b1;
              sm_waddr         = unit_addr;
              sm_wdata         = sm_rdata;
              sm_wdata.wt_flag = 1'b1;
            end
          end
        endcase
      end
      S_ZERO: begin
        wm_we    = 1'b1;
        wm_waddr = addr_q;
        if (cr_last) begin
          sm_we = 1'b1;
          if (mode_q == MODE_COLUMN) sm_wdata.col_flag = 1'b1;
          else                       sm_wdata.row_flag = 1'b1;
        end
      end
      default: ;
    endcase
  end

  mpe_ram #(.Width($bits(wword_t)), .Depth(Depth)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wm_we),
    .waddr_i (wm_waddr),
    .wdata_i (wm_wdata),
    .raddr_i (wm_raddr),
    .rdata_o (wm_rdata)
  );

  mpe_ram #(.Width($bits(sword_t)), .Depth(Depth)) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .raddr_i (sm_raddr),
    .rdata_o (sm_rdata)
  );

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_WEIGHT;
      thr_q       <= '0;
      tgt_q       <= '0;
      step_q      <= '0;
      rows_q      <= 7'd64;
      cols_q      <= 7'd64;
      wcount_q    <= '0;
      ccount_q    <= '0;
      rcount_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MODE:   mode_q <= mode_e'(cfg_data_i[1:0]);
          CFG_THRESH: thr_q  <= cfg_data_i[15:0];
          CFG_TARGET: tgt_q  <= $signed(cfg_data_i);
          CFG_STEP:   step_q <= cfg_data_i[30:0];
          CFG_ROWS:   rows_q <= cfg_data_i[6:0];
          CFG_COLS:   cols_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end

      if (w_prune && wcount_q != WCountMax) wcount_q <= wcount_q + 13'd1;
      if (cr_last) begin
        if (mode_q == MODE_COLUMN) begin
          if (ccount_q != UCountMax) ccount_q <= ccount_q + 7'd1;
        end else begin
          if (rcount_q != UCountMax) rcount_q <= rcount_q + 7'd1;
        end
      end

      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i)                                  out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  assign rank_full = {base_q[31:0], 16'b0} - {{15{diff_q[32]}}, diff_q};

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= op_e'(operation_i);
      row_q   <= row_index_i;
      col_q   <= col_index_i;
      wval_q  <= weight_value_i;
      sval_q  <= score_value_i;
      res_w_q <= '0;
      res_m_q <= 1'b0;
      now_q   <= 1'b0;
      was_q   <= 1'b0;
      rank_q  <= '0;
    end

    case (state_q)
      S_EXEC: begin
        sword_q     <= sm_rdata;
        unit_addr_q <= unit_addr;
        len_q       <= len_d;
        thrlen_q    <= SW'(thr_q) * SW'(len_d);
        sum_q       <= '0;
        issue_q     <= '0;
        recv_q      <= '0;
        pend_q      <= 1'b0;
        if (mode_q == MODE_COLUMN) begin
          start_q  <= AW'(col_q);
          addr_q   <= AW'(col_q);
          stride_q <= AW'(MAX_COLS);
        end else begin
          start_q  <= AW'(32'(row_q) * MAX_COLS);
          addr_q   <= AW'(32'(row_q) * MAX_COLS);
          stride_q <= AW'(1);
        end
        if (op_q == OP_RD_WEIGHT && in_store) begin
          res_w_q <= wm_rdata.weight;
          res_m_q <= wm_rdata.mask;
        end
        if (op_q == OP_CHECK && in_area && unit_flag) was_q <= 1'b1;
        if (w_prune) now_q <= 1'b1;
      end
      S_SUM: begin
        // reads are issued ahead of the accumulate; each read's data is summed in the cycle after
        pend_q <= (issue_q != len_q);
        if (issue_q != len_q) begin
          addr_q  <= addr_q + stride_q;
          issue_q <= issue_q + LW'(1);
        end
        if (pend_q) begin
          sum_q  <= sum_q + SW'(mag16(wm_rdata.weight));
          recv_q <= recv_q + LW'(1);
        end
      end
      S_DECIDE: begin
        addr_q  <= start_q;
        issue_q <= '0;
      end
      S_ZERO: begin
        addr_q  <= addr_q + stride_q;
        issue_q <= issue_q + LW'(1);
        if (cr_last) now_q <= 1'b1;
      end
      S_RANK1: begin
        diff_q <= 33'(sword_q.score) - 33'(tgt_q);
        base_q <= $signed({2'b00, step_q}) - $signed(33'(RankOffset));
      end
      S_RANK2: begin
        rank_q <= $signed(rank_full);
      end
      default: ;
    endcase

    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      weight_read_o     <= res_w_q;
      mask_read_o       <= res_m_q;
      unit_pruned_now_o <= now_q;
      unit_was_pruned_o <= was_q;
      rank_value_o      <= rank_q;
      case (mode_q)
        MODE_WEIGHT: pruned_units_o <= wcount_q;
        MODE_COLUMN: pruned_units_o <= {6'd0, ccount_q};
        MODE_ROW:    pruned_units_o <= {6'd0, rcount_q};
        default:     pruned_units_o <= '0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_now_xor_was: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(unit_pruned_now_o && unit_was_pruned_o))
    else $error("unit reported both pruned now and already pruned");

  a_prune_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unit_pruned_now_o) |-> (weight_read_o == 16'sd0 && !mask_read_o))
    else $error("check result carries read data");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (wcount_q >= $past(wcount_q)))
    else $error("weight prune count went down");

  a_zero_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ZERO) |-> (issue_q < len_q))
    else $error("zeroing pass ran past the unit length");

endmodule
